// File: hw/rtl/mde_pkg.sv
package mde_pkg;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // input kind codes
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // one burst of results caused by a single input transaction
  typedef struct packed {
    logic       load;      // burst has at least one result
    logic       done;      // single done notice
    logic [2:0] n_prefix;  // held marker bytes to replay
    logic       has_c;     // new byte follows the replay
    logic [7:0] c;
  } burst_t;

  // byte of the end-of-data marker at a position
  function automatic logic [7:0] marker_byte(logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = CHAR_CR;
      3'd1:    b = CHAR_LF;
      3'd2:    b = CHAR_DOT;
      3'd3:    b = CHAR_CR;
      3'd4:    b = CHAR_LF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/mail_data_end_detector_core.sv
// first result of an input transaction appears in the cycle after it is accepted
// throughput: one input per cycle while each input yields at most one result
// and m_tready is high; an input causing n results (up to five) holds off the next input
// until its last result is taken; the single output register plays one result a cycle
// reset (rst, synchronous, active high) empties the output and sets the after-crlf phase
module mail_data_end_detector_core (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] kind: 0 data byte, 1 restart
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] has_byte, [1] message_done
  output logic       m_tlast    // last result of this input transaction
);
  import mde_pkg::*;

  logic   accept;
  burst_t desc;

  // an input transaction completes here
  assign accept = s_tvalid && s_tready;

  // marker matcher: phase register plus the result burst decision
  mde_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (s_tuser),
    .data_byte (s_tdata),
    .desc      (desc)
  );

  // result register: replays held marker bytes, then the new byte or done notice
  mde_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load_en  (accept),
    .desc     (desc),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: hw/rtl/mde_parser.sv
module mde_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            kind,
  input  logic [7:0]      data_byte,
  output mde_pkg::burst_t desc
);
  import mde_pkg::*;

  typedef enum logic [2:0] {
    PH_DATA  = 3'd0,
    PH_CR    = 3'd1,
    PH_CRLF  = 3'd2,
    PH_DOT   = 3'd3,
    PH_DOTCR = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  phase_t phase;
  phase_t phase_next;

  always_comb begin
    desc       = '0;
    desc.c     = data_byte;
    phase_next = phase;
    if (kind == KIND_RESTART) begin
      phase_next = PH_CRLF;
    end else if (phase >= PH_DONE) begin
      phase_next = phase;
    end else if (data_byte == marker_byte(phase)) begin
      if (phase == PH_DOTCR) begin
        desc.load  = 1'b1;
        desc.done  = 1'b1;
        phase_next = PH_DONE;
      end else begin
        phase_next = phase_t'(phase + 3'd1);
      end
    end else begin
      desc.n_prefix = phase;
      if (data_byte == CHAR_CR) begin
        desc.has_c = 1'b0;
        phase_next = PH_CR;
      end else begin
        desc.has_c = 1'b1;
        phase_next = PH_DATA;
      end
      desc.load = (phase != PH_DATA) || desc.has_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CRLF;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_RESTART |=> phase == PH_CRLF)
    else $error("restart did not return to after-crlf phase");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE && kind == KIND_DATA |-> !desc.load)
    else $error("result after end of message");

  a_done_alone: assert property (@(posedge clk) disable iff (rst)
    desc.done |-> desc.n_prefix == 3'd0 && !desc.has_c)
    else $error("done notice mixed with payload");

endmodule

// File: hw/rtl/mde_burst.sv
module mde_burst (
  input  logic            clk,
  input  logic            rst,
  input  logic            load_en,
  input  mde_pkg::burst_t desc,
  output logic            ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);
  import mde_pkg::*;

  logic       busy;
  burst_t     cur;
  logic [2:0] idx;
  logic       last_w;

  always_comb begin
    if (cur.done) begin
      m_tdata = 8'h00;
      m_tuser = 2'b10;
      last_w  = 1'b1;
    end else if (idx < cur.n_prefix) begin
      m_tdata = marker_byte(idx);
      m_tuser = 2'b01;
      last_w  = (3'(idx + 3'd1) == cur.n_prefix) && !cur.has_c;
    end else begin
      m_tdata = cur.c;
      m_tuser = 2'b01;
      last_w  = 1'b1;
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = last_w;
  assign ready    = !busy || (m_tready && last_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (ready) begin
      busy <= load_en && desc.load;
      idx  <= 3'd0;
    end else if (m_tready) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      cur <= desc;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy && !cur.done |-> idx <= cur.n_prefix)
    else $error("replay index past held bytes");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !m_tready |=> busy && $stable(idx))
    else $error("burst advanced while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    busy && cur.done |-> last_w && idx == 3'd0)
    else $error("done notice not a single last result");

endmodule
